// ===== design/h2r_pkg.sv =====
`default_nettype none

package h2r_pkg;

  // Hue scale: 64 units per degree
  localparam int HUE_FULL   = 23040;  // 360 degrees
  localparam int HUE_SECTOR = 3840;   // 60 degrees
  localparam int FRAC_ONE   = 4096;   // 1.0 for saturation, brightness, hue fraction
  localparam int ONE_24     = 1 << 24;

  // floor(r / 15) == (r * RECIP_15) >> 16 for every r below one sector (3840)
  localparam int RECIP_15   = 4370;

  localparam int QUEUE_DEPTH = 4;

  localparam int HUE_W  = 15;
  localparam int FRAC_W = 13;
  localparam int POS_W  = 12;
  localparam int CH_W   = 8;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // Hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SECT_R_Y = 3'd0,
    SECT_Y_G = 3'd1,
    SECT_G_C = 3'd2,
    SECT_C_B = 3'd3,
    SECT_B_M = 3'd4,
    SECT_M_R = 3'd5
  } sector_t;

  // Classified pixel handed from front end to back end
  typedef struct packed {
    sector_t             sector;
    logic [POS_W-1:0]    frac;  // position in sector, 4096 = 1.0
    logic [FRAC_W-1:0]   sat;   // clamped to 4096
    logic [FRAC_W-1:0]   bri;   // clamped to 4096
  } item_t;

endpackage

`default_nettype wire

// ===== design/h2r_front.sv =====
`default_nettype none

module h2r_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [h2r_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output h2r_pkg::item_t                       push_item
);

  logic                         a_valid_r;
  logic                         a_valid_nxt;
  h2r_pkg::item_t               a_item_r;
  h2r_pkg::item_t               a_item_nxt;

  logic [h2r_pkg::HUE_W-1:0]    hue_in;
  logic [h2r_pkg::HUE_W-1:0]    hue_w;
  logic [h2r_pkg::FRAC_W-1:0]   sat_in;
  logic [h2r_pkg::FRAC_W-1:0]   bri_in;
  logic [h2r_pkg::HUE_W-1:0]    base;
  logic [h2r_pkg::HUE_W-1:0]    diff;
  logic [h2r_pkg::POS_W-1:0]    rem;
  logic [24:0]                  rem_scaled;
  h2r_pkg::sector_t             sector;

  assign hue_in = in_tdata[14:0];
  assign sat_in = in_tdata[27:15];
  assign bri_in = in_tdata[40:28];

  assign hue_w = (hue_in >= h2r_pkg::HUE_W'(h2r_pkg::HUE_FULL)) ? '0 : hue_in;

  always_comb begin
    if (hue_w >= h2r_pkg::HUE_W'(5 * h2r_pkg::HUE_SECTOR)) begin
      sector = h2r_pkg::SECT_M_R;
      base   = h2r_pkg::HUE_W'(5 * h2r_pkg::HUE_SECTOR);
    end else if (hue_w >= h2r_pkg::HUE_W'(4 * h2r_pkg::HUE_SECTOR)) begin
      sector = h2r_pkg::SECT_B_M;
      base   = h2r_pkg::HUE_W'(4 * h2r_pkg::HUE_SECTOR);
    end else if (hue_w >= h2r_pkg::HUE_W'(3 * h2r_pkg::HUE_SECTOR)) begin
      sector = h2r_pkg::SECT_C_B;
      base   = h2r_pkg::HUE_W'(3 * h2r_pkg::HUE_SECTOR);
    end else if (hue_w >= h2r_pkg::HUE_W'(2 * h2r_pkg::HUE_SECTOR)) begin
      sector = h2r_pkg::SECT_G_C;
      base   = h2r_pkg::HUE_W'(2 * h2r_pkg::HUE_SECTOR);
    end else if (hue_w >= h2r_pkg::HUE_W'(h2r_pkg::HUE_SECTOR)) begin
      sector = h2r_pkg::SECT_Y_G;
      base   = h2r_pkg::HUE_W'(h2r_pkg::HUE_SECTOR);
    end else begin
      sector = h2r_pkg::SECT_R_Y;
      base   = '0;
    end
  end

  // frac = floor(rem * 16 / 15) = rem + floor(rem / 15)
  assign diff       = hue_w - base;
  assign rem        = diff[h2r_pkg::POS_W-1:0];
  assign rem_scaled = {13'b0, rem} * 25'(h2r_pkg::RECIP_15);

  always_comb begin
    a_item_nxt        = a_item_r;
    a_item_nxt.sector = sector;
    a_item_nxt.frac   = rem + {3'b0, rem_scaled[24:16]};
    a_item_nxt.sat    = (sat_in > h2r_pkg::FRAC_W'(h2r_pkg::FRAC_ONE)) ?
                        h2r_pkg::FRAC_W'(h2r_pkg::FRAC_ONE) : sat_in;
    a_item_nxt.bri    = (bri_in > h2r_pkg::FRAC_W'(h2r_pkg::FRAC_ONE)) ?
                        h2r_pkg::FRAC_W'(h2r_pkg::FRAC_ONE) : bri_in;
  end

  assign in_tready  = !a_valid_r || push_ready;
  assign push_valid = a_valid_r;
  assign push_item  = a_item_r;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_tready) begin
      a_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_item_r <= a_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/h2r_queue.sv =====
`default_nettype none

module h2r_queue #(
  parameter int DEPTH = h2r_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire h2r_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output h2r_pkg::item_t      pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  h2r_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // occupancy tracks pointer distance
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== design/h2r_back.sv =====
`default_nettype none

module h2r_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             pop_valid,
  output logic                                  pop_ready,
  input  wire h2r_pkg::item_t                   pop_item,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [h2r_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  // floor(x * 255 / 2^36), x at most 2^36
  function automatic logic [h2r_pkg::CH_W-1:0] chan_byte(input logic [36:0] x);
    logic [44:0] prod;
    prod = {x, 8'b0} - {8'b0, x};
    return prod[43:36];
  endfunction

  logic             adv;

  // stage B: first products
  logic             b_valid_r;
  h2r_pkg::sector_t b_sector_r;
  logic [12:0]      b_bri_r;
  logic [23:0]      b_sf_r;   // s * f
  logic [24:0]      b_st_r;   // s * (1 - f)
  logic [24:0]      b_p_r;    // v * (1 - s)
  logic [12:0]      inv_frac;
  logic [12:0]      inv_sat;

  // stage C: channel terms, 2^36 = 1.0
  logic             c_valid_r;
  h2r_pkg::sector_t c_sector_r;
  logic [36:0]      c_v_r, c_p_r, c_q_r, c_t_r;
  logic [24:0]      q_mul, t_mul;

  // stage D: output register
  logic             d_valid_r;
  logic [h2r_pkg::OUT_TDATA_W-1:0] d_data_r, d_data_nxt;
  logic [36:0]      red_x, green_x, blue_x;

  assign adv       = !d_valid_r || out_tready;
  assign pop_ready = adv;

  assign inv_frac = h2r_pkg::FRAC_W'(h2r_pkg::FRAC_ONE) - {1'b0, pop_item.frac};
  assign inv_sat  = h2r_pkg::FRAC_W'(h2r_pkg::FRAC_ONE) - pop_item.sat;

  assign q_mul = 25'(h2r_pkg::ONE_24) - {1'b0, b_sf_r};
  assign t_mul = 25'(h2r_pkg::ONE_24) - b_st_r;

  always_comb begin
    unique case (c_sector_r)
      h2r_pkg::SECT_R_Y: begin red_x = c_v_r; green_x = c_t_r; blue_x = c_p_r; end
      h2r_pkg::SECT_Y_G: begin red_x = c_q_r; green_x = c_v_r; blue_x = c_p_r; end
      h2r_pkg::SECT_G_C: begin red_x = c_p_r; green_x = c_v_r; blue_x = c_t_r; end
      h2r_pkg::SECT_C_B: begin red_x = c_p_r; green_x = c_q_r; blue_x = c_v_r; end
      h2r_pkg::SECT_B_M: begin red_x = c_t_r; green_x = c_p_r; blue_x = c_v_r; end
      h2r_pkg::SECT_M_R: begin red_x = c_v_r; green_x = c_p_r; blue_x = c_q_r; end
      default:           begin red_x = c_v_r; green_x = c_p_r; blue_x = c_q_r; end
    endcase
    d_data_nxt = {chan_byte(blue_x), chan_byte(green_x), chan_byte(red_x)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= pop_valid;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sector_r <= pop_item.sector;
      b_bri_r    <= pop_item.bri;
      b_sf_r     <= {11'b0, pop_item.sat} * {12'b0, pop_item.frac};
      b_st_r     <= {12'b0, pop_item.sat} * {12'b0, inv_frac};
      b_p_r      <= {12'b0, pop_item.bri} * {12'b0, inv_sat};

      c_sector_r <= b_sector_r;
      c_v_r      <= {b_bri_r, 24'b0};
      c_p_r      <= {b_p_r, 12'b0};
      c_q_r      <= {24'b0, b_bri_r} * {12'b0, q_mul};
      c_t_r      <= {24'b0, b_bri_r} * {12'b0, t_mul};

      d_data_r   <= d_data_nxt;
    end
  end

  assign out_tvalid = d_valid_r;
  assign out_tdata  = d_data_r;

  // V is the largest term; zero saturation collapses all to V
  a_v_max: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> (c_p_r <= c_v_r && c_q_r <= c_v_r && c_t_r <= c_v_r))
    else $error("channel term above value");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && !out_tready) |=> ($stable(c_valid_r) && $stable(b_valid_r)))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

// ===== design/hsv_to_rgb_converter.sv =====
`default_nettype none

// HSV to RGB pixel converter. Takes one pixel per clock on the in_ stream
// while out_tready is high, and returns one 8-bit RGB pixel per input on the
// out_ stream, in order. Hue is in 1/64 degree (hue of 23040 or more counts
// as 0); saturation and brightness use 4096 = 1.0 and larger codes clamp to
// 1.0. Zero saturation gives gray. Each channel is floor(x * 255 / 4096) of
// the exact fraction x. With an empty queue, a word passes the front-end
// register, the queue and the back-end stages before its result is valid.
// Structure: a one-register front end (hue wrap, sector compare, sector
// fraction) feeds a small word queue; the back end is a three-stage multiply
// pipeline (s*f products, v*terms, sector mux and byte scaling into the
// output register). The 13 by 25 bit term multiplies of the second back-end
// stage set the per-clock path; byte scaling is a shift and subtract. Both
// sides stall independently; the queue holds QUEUE_DEPTH words.
module hsv_to_rgb_converter #(
  parameter int QUEUE_DEPTH = h2r_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [14:0] hue, [27:15] saturation, [40:28] brightness, [47:41] zero
  input  wire logic [h2r_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [h2r_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  logic           push_valid, push_ready;
  h2r_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  h2r_pkg::item_t pop_item;

  h2r_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  h2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  h2r_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
